FILE: src/multichannel_burst_hit_detector_assert.svh
// Assertion macros for the burst hit detector checker.
// Depends on nothing; included by the checker file only.
`ifndef MULTICHANNEL_BURST_HIT_DETECTOR_ASSERT_SVH
`define MULTICHANNEL_BURST_HIT_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MBHD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("burst hit detector check failed");

// Next-cycle implication, disabled while reset is high.
`define MBHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("burst hit detector check failed");

`endif

FILE: src/mbhd_pkg.sv
// Shared types and constants of the multichannel burst hit detector.
// Depends on nothing; the files that use it refer to it by scoped names.
package mbhd_pkg;

   localparam int LEVEL_WIDTH     = 15;
   localparam int ID_WIDTH        = 16;
   localparam int REPEAT_WIDTH    = 4;
   localparam int CFG_FIELD_WIDTH = 24;
   localparam int ADDR_WIDTH      = 5;
   localparam int DATA_WIDTH      = 32;

   localparam int CHANNELS_DEFAULT     = 15;
   localparam int DECODE_INDEX_DEFAULT = 7;
   localparam int COUNT_WIDTH_DEFAULT  = 24;

   localparam longint MIN_BURST_RESET   = 200;
   localparam longint HOLD_RESET        = 600000;
   localparam longint FLASH_ON_RESET    = 150000;
   localparam longint FLASH_OFF_RESET   = 150000;
   localparam longint DEDUP_RESET       = 1500000;
   localparam logic [REPEAT_WIDTH-1:0] FLASH_REPEATS_RESET = 4'd3;

   localparam logic [ID_WIDTH-1:0] SEQ_RESET = 16'hFFFF;

   typedef enum logic [2:0] {
      REG_MIN_BURST     = 3'd0,
      REG_HOLD          = 3'd1,
      REG_FLASH_ON      = 3'd2,
      REG_FLASH_OFF     = 3'd3,
      REG_FLASH_REPEATS = 3'd4,
      REG_DEDUP         = 3'd5
   } mbhd_reg_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] levels;
      logic                   decode_activity;
      logic                   frame_valid;
      logic [ID_WIDTH-1:0]    player_id;
      logic [ID_WIDTH-1:0]    shot_seq;
   } mbhd_req_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] hit_mask;
      logic                   flash_on;
      logic                   shot_accepted;
      logic                   mask_changed;
   } mbhd_rsp_type;

   typedef struct packed {
      logic flash_on;
      logic shot_accepted;
   } mbhd_shot_status_type;

endpackage

FILE: src/mbhd_lane.sv
// One receiver channel: low burst counter, hit hold counter and level history.
// Depends on mbhd_pkg only through the top level; no package items used here.
module mbhd_lane #(
   parameter int COUNT_WIDTH = 24,
   parameter bit IS_DECODE   = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   level,
   input  logic                   activity,
   input  logic [COUNT_WIDTH-1:0] min_burst,
   input  logic [COUNT_WIDTH-1:0] hold_ticks,
   output logic                   hit
);

   logic [COUNT_WIDTH-1:0] low_run_ff, low_run_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic                   prior_ff, prior_in;
   logic [COUNT_WIDTH-1:0] run_inc;

   always_comb begin
      run_inc    = (low_run_ff == '1) ? low_run_ff : low_run_ff + COUNT_WIDTH'(1);
      low_run_in = low_run_ff;
      prior_in   = prior_ff;
      hold_in    = (hold_ff != '0) ? hold_ff - COUNT_WIDTH'(1) : hold_ff;
      if (IS_DECODE) begin
         // The decode channel is qualified by the activity pulse alone.
         if (activity) begin
            hold_in = hold_ticks;
         end
      end else begin
         prior_in = level;
         if (!level) begin
            low_run_in = prior_ff ? '0 : run_inc;
            if (low_run_in >= min_burst) begin
               hold_in = hold_ticks;
            end
         end else if (!prior_ff) begin
            // Rising edge ends the burst; its length includes this tick.
            if (run_inc >= min_burst) begin
               hold_in = hold_ticks;
            end
         end
      end
      hit = (hold_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_run_ff <= '0;
         hold_ff    <= '0;
         prior_ff   <= 1'b1;
      end else if (accept) begin
         low_run_ff <= low_run_in;
         hold_ff    <= hold_in;
         prior_ff   <= prior_in;
      end
   end

endmodule

FILE: src/mbhd_flash.sv
// Shot deduplication window and the on/off flash sequencer.
// Depends on mbhd_pkg for identifier widths, reset values and the status struct.
module mbhd_flash #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 frame_valid,
   input  logic [mbhd_pkg::ID_WIDTH-1:0]        player_id,
   input  logic [mbhd_pkg::ID_WIDTH-1:0]        shot_seq,
   input  logic [COUNT_WIDTH-1:0]               on_ticks,
   input  logic [COUNT_WIDTH-1:0]               period,
   input  logic                                 flash_empty,
   input  logic [mbhd_pkg::REPEAT_WIDTH-1:0]    repeats,
   input  logic [COUNT_WIDTH-1:0]               dedup_ticks,
   output mbhd_pkg::mbhd_shot_status_type       status
);

   logic                              active_ff, active_in;
   logic [COUNT_WIDTH-1:0]            phase_ff, phase_in;
   logic [mbhd_pkg::REPEAT_WIDTH-1:0] done_ff, done_in;
   logic [mbhd_pkg::ID_WIDTH-1:0]     last_player_ff, last_player_in;
   logic [mbhd_pkg::ID_WIDTH-1:0]     last_shot_ff, last_shot_in;
   logic [COUNT_WIDTH-1:0]            since_ff, since_in;

   logic [COUNT_WIDTH-1:0]            since_inc;
   logic [COUNT_WIDTH-1:0]            phase_inc;
   logic [mbhd_pkg::REPEAT_WIDTH-1:0] done_inc;
   logic                              dup;
   logic                              accepted;

   always_comb begin
      since_inc = (since_ff == '1) ? since_ff : since_ff + COUNT_WIDTH'(1);
      phase_inc = (phase_ff == '1) ? phase_ff : phase_ff + COUNT_WIDTH'(1);
      done_inc  = done_ff + mbhd_pkg::REPEAT_WIDTH'(1);

      active_in = active_ff;
      phase_in  = phase_ff;
      done_in   = done_ff;

      // Advance a running flash by one tick.
      if (active_ff) begin
         if (flash_empty) begin
            active_in = 1'b0;
         end else if (phase_inc >= period) begin
            phase_in = '0;
            done_in  = done_inc;
            if (done_inc >= repeats || done_inc == '0) begin
               active_in = 1'b0;
            end
         end else begin
            phase_in = phase_inc;
         end
      end

      dup      = (player_id == last_player_ff) && (shot_seq == last_shot_ff) &&
                 (since_inc < dedup_ticks);
      accepted = frame_valid && !dup;

      last_player_in = last_player_ff;
      last_shot_in   = last_shot_ff;
      since_in       = since_inc;
      if (accepted) begin
         last_player_in = player_id;
         last_shot_in   = shot_seq;
         since_in       = '0;
         active_in      = 1'b1;
         phase_in       = '0;
         done_in        = '0;
      end

      // An empty sequence ends at once and never shows its on phase.
      if (flash_empty) begin
         active_in = 1'b0;
      end

      status.flash_on      = active_in && (phase_in < on_ticks);
      status.shot_accepted = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         phase_ff       <= '0;
         done_ff        <= '0;
         last_player_ff <= mbhd_pkg::SEQ_RESET;
         last_shot_ff   <= mbhd_pkg::SEQ_RESET;
         since_ff       <= '0;
      end else if (accept) begin
         active_ff      <= active_in;
         phase_ff       <= phase_in;
         done_ff        <= done_in;
         last_player_ff <= last_player_in;
         last_shot_ff   <= last_shot_in;
         since_ff       <= since_in;
      end
   end

endmodule

FILE: src/mbhd_merge.sv
// Merges lane hits into the result, tracks mask changes and buffers results.
// Depends on mbhd_pkg for the result and status structs.
module mbhd_merge #(
   parameter int CHANNELS = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [CHANNELS-1:0]            hits,
   input  mbhd_pkg::mbhd_shot_status_type status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output mbhd_pkg::mbhd_rsp_type         rsp_data,
   output logic                           req_ready
);

   logic [mbhd_pkg::LEVEL_WIDTH-1:0] mask;
   logic [mbhd_pkg::LEVEL_WIDTH-1:0] prior_mask_ff;
   mbhd_pkg::mbhd_rsp_type           result;

   logic                   out_valid_ff, out_valid_in;
   mbhd_pkg::mbhd_rsp_type out_ff, out_in;
   logic                   skid_valid_ff, skid_valid_in;
   mbhd_pkg::mbhd_rsp_type skid_ff, skid_in;
   logic                   pop;

   // Channels past the output width are computed but never shown.
   for (genvar i = 0; i < mbhd_pkg::LEVEL_WIDTH; i++) begin : g_mask
      if (i < CHANNELS) begin : g_used
         assign mask[i] = hits[i];
      end else begin : g_unused
         assign mask[i] = 1'b0;
      end
   end

   always_comb begin
      result.hit_mask      = mask;
      result.flash_on      = status.flash_on;
      result.shot_accepted = status.shot_accepted;
      result.mask_changed  = (mask != prior_mask_ff);

      pop           = out_valid_ff && rsp_ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         prior_mask_ff <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            prior_mask_ff <= mask;
         end
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign req_ready = !skid_valid_ff;

endmodule

FILE: src/multichannel_burst_hit_detector.sv
// Multichannel burst hit detector: top level with the register file and lanes.
// Depends on mbhd_pkg, mbhd_lane, mbhd_flash and mbhd_merge.
//
// Usage: each transfer on the req_ channel is one microsecond tick carrying
// the active-low levels of the receiver channels, the decode activity pulse
// and an optional decoded frame. Each accepted tick yields exactly one
// transfer on the rsp_ channel with the hit mask, the flash phase, whether
// the frame was taken as a new shot, and whether the mask changed.
// All channels are evaluated in parallel lanes in the cycle of acceptance,
// so a tick is taken every clock while req_ready is high. Results wait in
// a two-entry output buffer; when the receiver stalls, the block keeps
// accepting until both entries are full, and req_ready drops only then.
// It rises again in the cycle after the receiver takes a result. Reset
// clears all burst, hold, flash and deduplication state, loads the register
// defaults and empties the output buffer. The APB-style port writes one
// register per access cycle. The user must write it only while no tick is
// in flight; the block does not enforce it. Reads return the stored value.
module multichannel_burst_hit_detector #(
   parameter int CHANNELS     = mbhd_pkg::CHANNELS_DEFAULT,
   parameter int DECODE_INDEX = mbhd_pkg::DECODE_INDEX_DEFAULT,
   parameter int COUNT_WIDTH  = mbhd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mbhd_pkg::mbhd_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mbhd_pkg::mbhd_rsp_type            rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mbhd_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [mbhd_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [mbhd_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready
);

   // Counter registers are clamped to the counter range on write and at reset.
   localparam int WIDE = (COUNT_WIDTH > mbhd_pkg::CFG_FIELD_WIDTH) ?
                         COUNT_WIDTH : mbhd_pkg::CFG_FIELD_WIDTH;
   localparam longint CNT_MAX_L = (longint'(1) << COUNT_WIDTH) - 1;
   localparam logic [WIDE-1:0] CNT_MAX_W = WIDE'(CNT_MAX_L);

   localparam logic [COUNT_WIDTH-1:0] RST_MIN_BURST = COUNT_WIDTH'(
      (mbhd_pkg::MIN_BURST_RESET > CNT_MAX_L) ? CNT_MAX_L : mbhd_pkg::MIN_BURST_RESET);
   localparam logic [COUNT_WIDTH-1:0] RST_HOLD = COUNT_WIDTH'(
      (mbhd_pkg::HOLD_RESET > CNT_MAX_L) ? CNT_MAX_L : mbhd_pkg::HOLD_RESET);
   localparam logic [COUNT_WIDTH-1:0] RST_FLASH_ON = COUNT_WIDTH'(
      (mbhd_pkg::FLASH_ON_RESET > CNT_MAX_L) ? CNT_MAX_L : mbhd_pkg::FLASH_ON_RESET);
   localparam logic [COUNT_WIDTH-1:0] RST_FLASH_OFF = COUNT_WIDTH'(
      (mbhd_pkg::FLASH_OFF_RESET > CNT_MAX_L) ? CNT_MAX_L : mbhd_pkg::FLASH_OFF_RESET);
   localparam logic [COUNT_WIDTH-1:0] RST_DEDUP = COUNT_WIDTH'(
      (mbhd_pkg::DEDUP_RESET > CNT_MAX_L) ? CNT_MAX_L : mbhd_pkg::DEDUP_RESET);
   localparam longint RST_SUM = longint'(RST_FLASH_ON) + longint'(RST_FLASH_OFF);
   localparam logic [COUNT_WIDTH-1:0] RST_PERIOD = COUNT_WIDTH'(
      (RST_SUM > CNT_MAX_L) ? CNT_MAX_L : RST_SUM);
   localparam bit RST_EMPTY = (RST_PERIOD == '0) ||
                              (mbhd_pkg::FLASH_REPEATS_RESET == '0);

   logic [COUNT_WIDTH-1:0] min_burst_ff, min_burst_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic [COUNT_WIDTH-1:0] flash_on_ff, flash_on_in;
   logic [COUNT_WIDTH-1:0] flash_off_ff, flash_off_in;
   logic [mbhd_pkg::REPEAT_WIDTH-1:0] repeats_ff, repeats_in;
   logic [COUNT_WIDTH-1:0] dedup_ff, dedup_in;
   // The flash period and the empty-sequence flag follow the registers they
   // are built from, so the per-tick path holds only compares.
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic                   flash_empty_ff, flash_empty_in;

   logic                   cfg_write;
   logic [2:0]             reg_index;
   logic [WIDE-1:0]        wdata_wide;
   logic [COUNT_WIDTH-1:0] wdata_cnt;
   logic [COUNT_WIDTH:0]   period_sum;

   logic                            accept;
   logic [CHANNELS-1:0]             hits;
   mbhd_pkg::mbhd_shot_status_type  shot_status;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[mbhd_pkg::ADDR_WIDTH-1:2];

   always_comb begin
      wdata_wide = WIDE'(pwdata[mbhd_pkg::CFG_FIELD_WIDTH-1:0]);
      wdata_cnt  = (wdata_wide > CNT_MAX_W) ? '1 : wdata_wide[COUNT_WIDTH-1:0];

      min_burst_in = min_burst_ff;
      hold_in      = hold_ff;
      flash_on_in  = flash_on_ff;
      flash_off_in = flash_off_ff;
      repeats_in   = repeats_ff;
      dedup_in     = dedup_ff;
      if (cfg_write) begin
         case (reg_index)
            mbhd_pkg::REG_MIN_BURST:     min_burst_in = wdata_cnt;
            mbhd_pkg::REG_HOLD:          hold_in      = wdata_cnt;
            mbhd_pkg::REG_FLASH_ON:      flash_on_in  = wdata_cnt;
            mbhd_pkg::REG_FLASH_OFF:     flash_off_in = wdata_cnt;
            mbhd_pkg::REG_FLASH_REPEATS:
               repeats_in = pwdata[mbhd_pkg::REPEAT_WIDTH-1:0];
            mbhd_pkg::REG_DEDUP:         dedup_in     = wdata_cnt;
            default: ;
         endcase
      end

      period_sum     = {1'b0, flash_on_in} + {1'b0, flash_off_in};
      period_in      = period_sum[COUNT_WIDTH] ? '1 : period_sum[COUNT_WIDTH-1:0];
      flash_empty_in = (period_in == '0) || (repeats_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_burst_ff   <= RST_MIN_BURST;
         hold_ff        <= RST_HOLD;
         flash_on_ff    <= RST_FLASH_ON;
         flash_off_ff   <= RST_FLASH_OFF;
         repeats_ff     <= mbhd_pkg::FLASH_REPEATS_RESET;
         dedup_ff       <= RST_DEDUP;
         period_ff      <= RST_PERIOD;
         flash_empty_ff <= RST_EMPTY;
      end else begin
         min_burst_ff   <= min_burst_in;
         hold_ff        <= hold_in;
         flash_on_ff    <= flash_on_in;
         flash_off_ff   <= flash_off_in;
         repeats_ff     <= repeats_in;
         dedup_ff       <= dedup_in;
         period_ff      <= period_in;
         flash_empty_ff <= flash_empty_in;
      end
   end

   // Register readback is combinational on the address.
   always_comb begin
      case (reg_index)
         mbhd_pkg::REG_MIN_BURST:     prdata = mbhd_pkg::DATA_WIDTH'(min_burst_ff);
         mbhd_pkg::REG_HOLD:          prdata = mbhd_pkg::DATA_WIDTH'(hold_ff);
         mbhd_pkg::REG_FLASH_ON:      prdata = mbhd_pkg::DATA_WIDTH'(flash_on_ff);
         mbhd_pkg::REG_FLASH_OFF:     prdata = mbhd_pkg::DATA_WIDTH'(flash_off_ff);
         mbhd_pkg::REG_FLASH_REPEATS: prdata = mbhd_pkg::DATA_WIDTH'(repeats_ff);
         mbhd_pkg::REG_DEDUP:         prdata = mbhd_pkg::DATA_WIDTH'(dedup_ff);
         default:                     prdata = '0;
      endcase
   end

   assign accept = req_valid && req_ready;

   // One lane per channel. Lanes beyond the level field see a steady low
   // level; the lane at the decode index follows the activity pulse.
   for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
      logic lane_level;
      if (n < mbhd_pkg::LEVEL_WIDTH) begin : g_level
         assign lane_level = req_data.levels[n];
      end else begin : g_tied
         assign lane_level = 1'b0;
      end
      mbhd_lane #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .IS_DECODE   (n == DECODE_INDEX)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .level      (lane_level),
         .activity   (req_data.decode_activity),
         .min_burst  (min_burst_ff),
         .hold_ticks (hold_ff),
         .hit        (hits[n])
      );
   end

   mbhd_flash #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_flash (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_valid (req_data.frame_valid),
      .player_id   (req_data.player_id),
      .shot_seq    (req_data.shot_seq),
      .on_ticks    (flash_on_ff),
      .period      (period_ff),
      .flash_empty (flash_empty_ff),
      .repeats     (repeats_ff),
      .dedup_ticks (dedup_ff),
      .status      (shot_status)
   );

   mbhd_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .hits      (hits),
      .status    (shot_status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_ready (req_ready)
   );

endmodule

FILE: src/mbhd_checker.sv
// Port-level checker for the burst hit detector, bound to the top level.
// Depends on mbhd_pkg and multichannel_burst_hit_detector_assert.svh.
`include "multichannel_burst_hit_detector_assert.svh"

module mbhd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input mbhd_pkg::mbhd_rsp_type rsp_data
);

   // A result appears only after a tick was taken.
   `MBHD_ASSERT_NOW(a_no_spurious_result, clock, reset, rsp_valid && !$past(rsp_valid), $past(req_valid && req_ready))

   // Input backpressure means the output buffer is full, so a result is shown.
   `MBHD_ASSERT_NOW(a_stall_needs_result, clock, reset, !req_ready, rsp_valid)

   // Once the receiver takes a result, a full buffer frees a slot and raises req_ready.
   `MBHD_ASSERT_NEXT(a_ready_recovers, clock, reset, !req_ready && rsp_ready, req_ready)

   // A stalled result transfer holds its payload.
   `MBHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind multichannel_burst_hit_detector mbhd_checker u_mbhd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_multichannel_burst_hit_detector.sv
// Self-checking testbench for the multichannel burst hit detector.
// Depends on mbhd_pkg, multichannel_burst_hit_detector and the files that it depends on.
`timescale 1ns / 1ps

module tb_multichannel_burst_hit_detector;

   localparam int NCH = mbhd_pkg::CHANNELS_DEFAULT;
   localparam int DEC = mbhd_pkg::DECODE_INDEX_DEFAULT;
   localparam int CW  = mbhd_pkg::COUNT_WIDTH_DEFAULT;
   localparam int LW  = mbhd_pkg::LEVEL_WIDTH;
   localparam int IW  = mbhd_pkg::ID_WIDTH;
   localparam int RW  = mbhd_pkg::REPEAT_WIDTH;
   localparam int DW  = mbhd_pkg::DATA_WIDTH;
   localparam logic [CW-1:0] CNT_TOP = '1;
   localparam logic [LW-1:0] IDLE = '1;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int NUM_PHASES = 8;
   localparam int SETTLE_CYCLES = 8;

   // Clock, reset and every block input start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mbhd_pkg::mbhd_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mbhd_pkg::mbhd_rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [mbhd_pkg::ADDR_WIDTH-1:0] paddr = '0;
   logic [DW-1:0] pwdata = '0;
   logic [DW-1:0] prdata;
   logic pready;

   multichannel_burst_hit_detector u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Register copies that the predictor works from.
   logic [CW-1:0] cfg_min;
   logic [CW-1:0] cfg_hold;
   logic [CW-1:0] cfg_on;
   logic [CW-1:0] cfg_off;
   logic [RW-1:0] cfg_rep;
   logic [CW-1:0] cfg_dedup;

   // Predictor state: per-channel burst length, hold countdown and last level,
   // plus the decode hold, the flash sequencer and the duplicate filter.
   logic [CW-1:0] burst_len [NCH];
   logic [CW-1:0] hold_cnt [NCH];
   logic last_lvl [NCH];
   logic [CW-1:0] dec_hold;
   logic fl_active;
   logic [CW-1:0] fl_phase;
   logic [RW-1:0] fl_cycles;
   logic [IW-1:0] seen_player;
   logic [IW-1:0] seen_shot;
   logic [CW-1:0] ticks_since;
   logic [LW-1:0] last_mask;

   // Results predicted for accepted ticks, oldest first.
   mbhd_pkg::mbhd_rsp_type pending_rsp [$];

   int fail_count = 0;
   int n_ticks = 0;
   int n_shots = 0;
   int n_hit_ticks = 0;
   int n_settings = 0;
   int calm_left [2] = '{0, 0};
   logic [LW-1:0] walk_levels = '1;

   // One directed step: either a register write or a tick, where a tick may
   // carry a result that is typed in by hand.
   typedef struct {
      bit is_cfg;
      mbhd_pkg::mbhd_reg_type reg_sel;
      logic [DW-1:0] value;
      mbhd_pkg::mbhd_req_type req;
      bit typed;
      mbhd_pkg::mbhd_rsp_type want;
   } dir_row_type;

   dir_row_type plan [$];
   logic [CW-1:0] phase_cfg [NUM_PHASES][6];

   // Advances the predictor by one tick and returns the result it causes.
   // The order follows the block: countdowns first, then the flash step, then
   // the channels, the frame filter and finally the outputs.
   function automatic mbhd_pkg::mbhd_rsp_type predict_tick(input mbhd_pkg::mbhd_req_type t);
      logic [CW:0] per_sum;
      logic [CW-1:0] per;
      logic [CW-1:0] run_len;
      logic [LW-1:0] mask;
      logic lvl;
      logic dup;
      mbhd_pkg::mbhd_rsp_type r;
      r = '0;
      mask = '0;
      // The flash period saturates at the counter maximum.
      per_sum = {1'b0, cfg_on} + {1'b0, cfg_off};
      per = per_sum[CW] ? CNT_TOP : per_sum[CW-1:0];

      if (dec_hold != 0) dec_hold = dec_hold - 1'b1;
      if (ticks_since != CNT_TOP) ticks_since = ticks_since + 1'b1;

      if (fl_active) begin
         if (per == 0 || cfg_rep == 0) begin
            fl_active = 1'b0;
         end else begin
            if (fl_phase != CNT_TOP) fl_phase = fl_phase + 1'b1;
            // A phase past a shortened period wraps into the next cycle.
            if (fl_phase >= per) begin
               fl_phase = '0;
               fl_cycles = fl_cycles + 1'b1;
               if (fl_cycles >= cfg_rep || fl_cycles == 0) fl_active = 1'b0;
            end
         end
      end

      for (int n = 0; n < NCH; n++) begin
         lvl = t.levels[n];
         if (hold_cnt[n] != 0) hold_cnt[n] = hold_cnt[n] - 1'b1;
         if (n == DEC) begin
            // The decode channel ignores its level and follows the pulse.
            if (t.decode_activity) dec_hold = cfg_hold;
            if (dec_hold != 0) mask[n] = 1'b1;
         end else begin
            if (!lvl) begin
               if (last_lvl[n]) burst_len[n] = '0;
               else if (burst_len[n] != CNT_TOP) burst_len[n] = burst_len[n] + 1'b1;
               if (burst_len[n] >= cfg_min) hold_cnt[n] = cfg_hold;
            end else if (!last_lvl[n]) begin
               // The rising edge counts the final low tick as well.
               run_len = (burst_len[n] == CNT_TOP) ? CNT_TOP : burst_len[n] + 1'b1;
               if (run_len >= cfg_min) hold_cnt[n] = cfg_hold;
            end
            last_lvl[n] = lvl;
            if (hold_cnt[n] != 0) mask[n] = 1'b1;
         end
      end

      if (t.frame_valid) begin
         dup = (t.player_id == seen_player) && (t.shot_seq == seen_shot) &&
               (ticks_since < cfg_dedup);
         if (!dup) begin
            seen_player = t.player_id;
            seen_shot = t.shot_seq;
            ticks_since = '0;
            fl_active = 1'b1;
            fl_phase = '0;
            fl_cycles = '0;
            r.shot_accepted = 1'b1;
         end
      end

      if (fl_active) begin
         if (per == 0 || cfg_rep == 0) fl_active = 1'b0;
         else r.flash_on = (fl_phase < cfg_on);
      end

      r.hit_mask = mask;
      r.mask_changed = (mask != last_mask);
      last_mask = mask;
      return r;
   endfunction

   // Wait drawn for the next item on one side, with stretches in which that
   // side never idles.
   function automatic int draw_wait(input int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(8, 40);
      return $urandom_range(0, 3);
   endfunction

   // Random tick. The levels mostly follow a walk whose flip rate tracks the
   // minimum burst length, so bursts land on both sides of the threshold.
   // Half of the frames repeat the last accepted shot to exercise the window.
   function automatic mbhd_pkg::mbhd_req_type random_tick();
      mbhd_pkg::mbhd_req_type t;
      int scale;
      scale = (cfg_min > 10) ? 12 : int'(cfg_min) + 2;
      if ($urandom_range(0, 15) == 0) begin
         walk_levels = LW'($urandom);
      end else begin
         for (int n = 0; n < NCH; n++)
            if ($urandom_range(0, scale) == 0) walk_levels[n] = ~walk_levels[n];
      end
      t.levels = walk_levels;
      t.decode_activity = ($urandom_range(0, 9) == 0);
      t.frame_valid = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 3))
         0, 1: begin
            t.player_id = seen_player;
            t.shot_seq = seen_shot;
         end
         2: begin
            t.player_id = $urandom_range(0, 1) ? mbhd_pkg::SEQ_RESET :
                          IW'($urandom_range(0, 2));
            t.shot_seq = $urandom_range(0, 1) ? mbhd_pkg::SEQ_RESET :
                         IW'($urandom_range(0, 2));
         end
         default: begin
            t.player_id = IW'($urandom);
            t.shot_seq = IW'($urandom);
         end
      endcase
      return t;
   endfunction

   function automatic void tick_row(input logic [LW-1:0] lv, input bit act,
                                    input bit fv, input logic [IW-1:0] pid,
                                    input logic [IW-1:0] seq, input bit typed,
                                    input mbhd_pkg::mbhd_rsp_type want);
      dir_row_type row;
      row.is_cfg = 1'b0;
      row.reg_sel = mbhd_pkg::REG_MIN_BURST;
      row.value = '0;
      row.req = {lv, act, fv, pid, seq};
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   function automatic void cfg_row(input mbhd_pkg::mbhd_reg_type r, input logic [DW-1:0] v);
      dir_row_type row;
      row.is_cfg = 1'b1;
      row.reg_sel = r;
      row.value = v;
      row.req = '0;
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   task automatic report(input string field, input int want, input int got);
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
   endtask

   // Drops req_valid right after the last transfer and waits until every
   // predicted result has come back, then lets the pipeline settle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write while the block is idle: setup cycle, then access cycle.
   // The predictor takes the new value at the edge where the block does.
   task automatic write_reg(input mbhd_pkg::mbhd_reg_type r, input logic [DW-1:0] v);
      settle();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (r)
         mbhd_pkg::REG_MIN_BURST:     cfg_min = v[CW-1:0];
         mbhd_pkg::REG_HOLD:          cfg_hold = v[CW-1:0];
         mbhd_pkg::REG_FLASH_ON:      cfg_on = v[CW-1:0];
         mbhd_pkg::REG_FLASH_OFF:     cfg_off = v[CW-1:0];
         mbhd_pkg::REG_FLASH_REPEATS: cfg_rep = v[RW-1:0];
         mbhd_pkg::REG_DEDUP:         cfg_dedup = v[CW-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Offers one tick after a random wait and holds it until the transfer.
   // At the accepting edge the predictor runs and queues its result, or the
   // hand-typed one for rows that carry it.
   task automatic send_tick(input mbhd_pkg::mbhd_req_type t, input bit typed,
                            input mbhd_pkg::mbhd_rsp_type want);
      int gap;
      mbhd_pkg::mbhd_rsp_type guess;
      gap = draw_wait(0);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_ready !== 1'b1);
      guess = predict_tick(t);
      pending_rsp.push_back(typed ? want : guess);
      n_ticks++;
      if (guess.shot_accepted) n_shots++;
      if (guess.hit_mask != 0) n_hit_ticks++;
   endtask

   // Stimulus: reset, the directed table, then random phases under several
   // register settings, the extremes among them.
   initial begin
      cfg_min = CW'(mbhd_pkg::MIN_BURST_RESET);
      cfg_hold = CW'(mbhd_pkg::HOLD_RESET);
      cfg_on = CW'(mbhd_pkg::FLASH_ON_RESET);
      cfg_off = CW'(mbhd_pkg::FLASH_OFF_RESET);
      cfg_rep = mbhd_pkg::FLASH_REPEATS_RESET;
      cfg_dedup = CW'(mbhd_pkg::DEDUP_RESET);
      for (int n = 0; n < NCH; n++) begin
         burst_len[n] = '0;
         hold_cnt[n] = '0;
         last_lvl[n] = 1'b1;
      end
      dec_hold = '0;
      fl_active = 1'b0;
      fl_phase = '0;
      fl_cycles = '0;
      seen_player = mbhd_pkg::SEQ_RESET;
      seen_shot = mbhd_pkg::SEQ_RESET;
      ticks_since = '0;
      last_mask = '0;

      // Settings per phase: min burst, hold, flash on, flash off, repeats, window.
      phase_cfg[0] = '{24'd0, 24'd0, 24'd1, 24'd0, 24'd1, 24'd0};
      phase_cfg[1] = '{24'd3, 24'd5, 24'd3, 24'd2, 24'd2, 24'd20};
      phase_cfg[2] = '{24'd1, 24'd12, 24'd4, 24'd4, 24'd15, 24'd60};
      phase_cfg[3] = '{24'd8, 24'd30, 24'd2, 24'd9, 24'd5, 24'd200};
      phase_cfg[4] = '{CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP, 24'd15, CNT_TOP};
      phase_cfg[5] = '{24'd5, 24'd7, 24'd0, 24'd0, 24'd3, 24'd30};
      phase_cfg[6] = '{24'd2, 24'd9, 24'd3, 24'd3, 24'd0, 24'd10};
      phase_cfg[7] = '{24'd0, CNT_TOP, 24'd6, 24'd0, 24'd7, 24'd100};

      // Straight after reset with default registers: an idle tick, the reset
      // value pair seen as a duplicate, a fresh shot starting the flash, the
      // decode pulse raising its bit, and a repeat of the shot filtered out.
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, {15'h0000, 1'b0, 1'b0, 1'b0});
      tick_row(IDLE, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, {15'h0000, 1'b0, 1'b0, 1'b0});
      tick_row(IDLE, 1'b0, 1'b1, 16'h0001, 16'h0002, 1'b1, {15'h0000, 1'b1, 1'b1, 1'b0});
      tick_row(IDLE, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, {15'h0080, 1'b1, 1'b0, 1'b1});
      tick_row(IDLE, 1'b0, 1'b1, 16'h0001, 16'h0002, 1'b1, {15'h0080, 1'b1, 1'b0, 1'b0});
      tick_row(15'h0000, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 1'b0, '0);
      // A zero threshold makes every low tick a hit; short holds then drain.
      cfg_row(mbhd_pkg::REG_MIN_BURST, 32'd0);
      cfg_row(mbhd_pkg::REG_HOLD, 32'd3);
      tick_row(15'h0000, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(15'h2AAA, 1'b1, 1'b0, 16'h5555, 16'hAAAA, 1'b0, '0);
      tick_row(15'h5555, 1'b0, 1'b0, 16'hAAAA, 16'h5555, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      // Channel 0: a burst one tick short of the threshold, then one that
      // only qualifies on its rising edge.
      cfg_row(mbhd_pkg::REG_MIN_BURST, 32'd3);
      tick_row(15'h7FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(15'h7FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(15'h7FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(15'h7FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(15'h7FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      // The period is shortened while a flash runs, then a new shot restarts it.
      cfg_row(mbhd_pkg::REG_FLASH_ON, 32'd2);
      cfg_row(mbhd_pkg::REG_FLASH_OFF, 32'd1);
      cfg_row(mbhd_pkg::REG_FLASH_REPEATS, 32'd2);
      tick_row(IDLE, 1'b0, 1'b1, 16'hABCD, 16'h1234, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      tick_row(IDLE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
      // Empty flash: zero repeats, then a zero period.
      cfg_row(mbhd_pkg::REG_FLASH_REPEATS, 32'd0);
      tick_row(IDLE, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0, '0);
      cfg_row(mbhd_pkg::REG_FLASH_ON, 32'd0);
      cfg_row(mbhd_pkg::REG_FLASH_OFF, 32'd0);
      cfg_row(mbhd_pkg::REG_FLASH_REPEATS, 32'd1);
      tick_row(IDLE, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, '0);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].value);
         else send_tick(plan[i].req, plan[i].typed, plan[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         for (int r = 0; r < 6; r++)
            write_reg(mbhd_pkg::mbhd_reg_type'(r), DW'(phase_cfg[p][r]));
         n_settings++;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_tick(random_tick(), 1'b0, '0);
      end

      settle();
      $display("Run covered %0d ticks over %0d random register settings plus the directed table.",
               n_ticks, n_settings);
      $display("Predicted %0d accepted shots and %0d ticks with a hit in the mask.",
               n_shots, n_hit_ticks);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side: stalls at random, and at each transfer compares the result
   // field by field with the oldest prediction.
   initial begin
      mbhd_pkg::mbhd_rsp_type want;
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(1);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_rsp.size() == 0) begin
            $error("result transfer with no tick waiting for it");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit_mask !== want.hit_mask)
               report("hit_mask", int'(want.hit_mask), int'(rsp_data.hit_mask));
            if (rsp_data.flash_on !== want.flash_on)
               report("flash_on", int'(want.flash_on), int'(rsp_data.flash_on));
            if (rsp_data.shot_accepted !== want.shot_accepted)
               report("shot_accepted", int'(want.shot_accepted),
                      int'(rsp_data.shot_accepted));
            if (rsp_data.mask_changed !== want.mask_changed)
               report("mask_changed", int'(want.mask_changed),
                      int'(rsp_data.mask_changed));
         end
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
